[rtl/core/axis_constrained_drag_solve_unit_defines.svh]
// Assertion macros for the constrained drag solver checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef AXIS_CONSTRAINED_DRAG_SOLVE_UNIT_DEFINES_SVH
`define AXIS_CONSTRAINED_DRAG_SOLVE_UNIT_DEFINES_SVH

// same-cycle implication
`define ACDS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ACDS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/acds_pkg.sv]
// Shared constants, codes and helper functions of the constrained drag solver.
// No dependencies; used by acds_mul, acds_div, acds_sqrt, the top level and the testbench.
package acds_pkg;

	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned MUL_W = 34;
	localparam int unsigned DIV_W = 64;
	localparam int unsigned SQRT_W = 64;

	localparam logic [63:0] ONE30 = 64'h0000_0000_4000_0000;
	localparam logic [63:0] PAR_EPS = (ONE30 + 64'd5000) / 64'd10000;

	localparam logic ACT_BEGIN = 1'b0;
	localparam logic ACT_MOVE = 1'b1;

	typedef enum logic [2:0] {
		CFG_START_X = 3'd0,
		CFG_START_Y = 3'd1,
		CFG_START_Z = 3'd2,
		CFG_AXIS_X = 3'd3,
		CFG_AXIS_Y = 3'd4,
		CFG_AXIS_Z = 3'd5
	} cfg_idx_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			r = -32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	// (p + 2^29) >> 30
	function automatic logic [33:0] rnd30(input logic [63:0] p);
		logic [63:0] s;
		s = p + 64'h0000_0000_2000_0000;
		return s[63:30];
	endfunction

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

endpackage

[rtl/core/acds_mul.sv]
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on acds_pkg.
module acds_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [acds_pkg::MUL_W-1:0]        a,
	input  logic [acds_pkg::MUL_W-1:0]        b,
	output logic                              done,
	output logic [2*acds_pkg::MUL_W-1:0]      p
);
	localparam int unsigned MW = acds_pkg::MUL_W;
	localparam int unsigned CW = $clog2(MW + 1);

	logic [MW-1:0]   a_q, b_q;
	logic [2*MW-1:0] acc_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic [MW:0]     sum;

	assign sum = {1'b0, acc_q[2*MW-1:MW]} + (b_q[0] ? {1'b0, a_q} : {(MW+1){1'b0}});
	assign p = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(MW - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[MW-1:1]};
			b_q <= b_q >> 1;
		end
	end

endmodule

[rtl/core/acds_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on acds_pkg.
module acds_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [acds_pkg::DIV_W-1:0]    dividend,
	input  logic [acds_pkg::DIV_W-1:0]    divisor,
	output logic                          done,
	output logic [acds_pkg::DIV_W-1:0]    quotient
);
	localparam int unsigned DW = acds_pkg::DIV_W;
	localparam int unsigned CW = $clog2(DW + 1);

	logic [DW-1:0] rem_q, quo_q, d_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial, diff;
	logic          ge;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff = trial - {1'b0, d_q};
	assign ge = trial >= {1'b0, d_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			d_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

endmodule

[rtl/core/acds_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on acds_pkg.
module acds_sqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [acds_pkg::SQRT_W-1:0]       radicand,
	output logic                              done,
	output logic [acds_pkg::SQRT_W/2-1:0]     root
);
	localparam int unsigned SW = acds_pkg::SQRT_W;
	localparam int unsigned STEPS = SW / 2;
	localparam int unsigned CW = $clog2(STEPS + 1);

	logic [SW-1:0] n_q, r_q, b_q, rb;
	logic [CW-1:0] cnt_q;
	logic          busy_q;

	assign rb = r_q + b_q;
	assign root = r_q[STEPS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			r_q <= '0;
			b_q <= {2'b01, {(SW-2){1'b0}}};
		end else if (busy_q) begin
			if (n_q >= rb) begin
				n_q <= n_q - rb;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

endmodule

[rtl/core/axis_constrained_drag_solve_unit.sv]
// Top level of the constrained drag solver: sequencer and datapath registers.
// Depends on acds_pkg, acds_mul, acds_div and acds_sqrt.
//
// Usage:
//   Configure start position and drag axis through cfg_we/cfg_index/cfg_data
//   while the block is idle. Each item on s_axis carries a ray (origin and
//   direction) and in tuser the action (begin or move). One result item
//   leaves on m_axis per input item: ok in tuser, the axis parameter, the
//   snapped movement and the new position in tdata.
//   One item is in work at a time. The axis and the ray are each normalized
//   (shift search, three squares and, unless the vector is short, a 32-step
//   square root and three 64-step divisions); then come nine products, the
//   denominator and numerator products, at most one more 64-step division
//   and up to three position products. A short ray skips these later steps.
//   Every product goes through the shared bit-serial multiplier, every
//   quotient through the shared restoring divider.
//   The result sits in an output register; the next item is accepted while it
//   waits, and a stalled receiver only holds the block in its final state.
//   Reset clears the stored begin parameter, sets the start position to zero
//   and the axis to +y, and empties the output register.
module axis_constrained_drag_solve_unit #(
	parameter int unsigned FRAC_BITS = acds_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// ray_org_x, ray_org_y, ray_org_z, ray_dir_x, ray_dir_y, ray_dir_z
	input  logic [191:0] s_axis_tdata,
	// action
	input  logic [0:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// axis_param, snapped_move, new_pos_x, new_pos_y, new_pos_z
	output logic [159:0] m_axis_tdata,
	// ok
	output logic [0:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	localparam int unsigned MW = acds_pkg::MUL_W;
	localparam int unsigned DW = acds_pkg::DIV_W;
	localparam logic [63:0] LEN_EPS = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
	localparam logic [63:0] EPS2 = LEN_EPS * LEN_EPS;
	localparam logic [35:0] HALF = 36'd1 << (FRAC_BITS - 1);
	localparam logic signed [35:0] DR_LIM = 36'sh1_FFFF_FFFF;

	typedef enum logic [4:0] {
		ST_IDLE, ST_NORM, ST_SQ_GO, ST_SQ_WAIT, ST_UNSH, ST_CHK, ST_SQRT_GO,
		ST_SQRT_WAIT, ST_UDIV_GO, ST_UDIV_WAIT, ST_DOT_GO, ST_DOT_WAIT,
		ST_DOT_END, ST_DD_GO, ST_DD_WAIT, ST_NUM_GO, ST_NUM_WAIT, ST_QCHK,
		ST_Q_GO, ST_Q_WAIT, ST_SNAP, ST_POS_GO, ST_POS_WAIT, ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic signed [31:0] st_q [3];
	logic signed [31:0] ax_q [3];

	// item and datapath
	logic               act_q, vsel_q, ok_q, mneg_q, nneg_q;
	logic signed [31:0] org_q [3];
	logic signed [31:0] dir_q [3];
	logic [31:0]        mag_q [3];
	logic               neg_q [3];
	logic [4:0]         k_q;
	logic [3:0]         cnt_q;
	logic [63:0]        sq_q, l2_q;
	logic [31:0]        len_q;
	logic signed [31:0] ua_q [3];
	logic signed [31:0] ur_q [3];
	logic signed [63:0] acc_q;
	logic signed [35:0] da_q, dr_q;
	logic signed [31:0] dot_q;
	logic [31:0]        den_q;
	logic [36:0]        n_q;
	logic signed [31:0] t_q, sp_q, snap_q;
	logic signed [31:0] pos_q [3];

	// arithmetic units
	logic              mul_start_q, div_start_q, sqrt_start_q;
	logic [MW-1:0]     mul_a_q, mul_b_q;
	logic [DW-1:0]     div_n_q, div_d_q;
	logic              mul_done, div_done, sqrt_done;
	logic [2*MW-1:0]   mul_p;
	logic [DW-1:0]     div_quo;
	logic [31:0]       sqrt_root;

	// output register
	logic               ov_q, ook_q;
	logic signed [31:0] ot_q, osnap_q;
	logic signed [31:0] opos_q [3];
	logic               out_load;

	acds_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start_q), .a(mul_a_q), .b(mul_b_q),
		.done(mul_done), .p(mul_p)
	);

	acds_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start_q), .dividend(div_n_q),
		.divisor(div_d_q), .done(div_done), .quotient(div_quo)
	);

	acds_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start_q), .radicand(sq_q),
		.done(sqrt_done), .root(sqrt_root)
	);

	// combinational helpers
	logic signed [32:0] diff [3];
	logic [32:0]        dmag [3];
	logic [31:0]        mx;
	logic [1:0]         lane;
	logic [MW-1:0]      dot_a, dot_b;
	logic               dot_neg;
	logic [63:0]        p64;
	logic [33:0]        pr;
	logic signed [35:0] prs;
	logic signed [63:0] ps;
	logic [33:0]        dotm;
	logic [31:0]        dotc;
	logic signed [35:0] drc;
	logic signed [37:0] num_c;
	logic [37:0]        num_m;
	logic [31:0]        uq;
	logic signed [32:0] v33;
	logic [32:0]        vmag;
	logic [35:0]        hsum, hval, sval;
	logic signed [31:0] snap_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = {org_q[i][31], org_q[i]} - {st_q[i][31], st_q[i]};
			dmag[i] = diff[i][32] ? (~diff[i] + 33'd1) : diff[i];
		end
		mx = mag_q[0];
		if (mag_q[1] > mx)
			mx = mag_q[1];
		if (mag_q[2] > mx)
			mx = mag_q[2];
	end

	// operands of the nine dot-phase products
	always_comb begin
		if (cnt_q < 4'd3) begin
			lane = cnt_q[1:0];
			dot_a = MW'(acds_pkg::mag32(ur_q[lane]));
			dot_b = MW'(acds_pkg::mag32(ua_q[lane]));
			dot_neg = ur_q[lane][31] ^ ua_q[lane][31];
		end else if (cnt_q < 4'd6) begin
			lane = 2'(cnt_q - 4'd3);
			dot_a = MW'(dmag[lane]);
			dot_b = MW'(acds_pkg::mag32(ua_q[lane]));
			dot_neg = diff[lane][32] ^ ua_q[lane][31];
		end else begin
			lane = 2'(cnt_q - 4'd6);
			dot_a = MW'(dmag[lane]);
			dot_b = MW'(acds_pkg::mag32(ur_q[lane]));
			dot_neg = diff[lane][32] ^ ur_q[lane][31];
		end
	end

	always_comb begin
		p64 = mul_p[63:0];
		pr = acds_pkg::rnd30(p64);
		prs = mneg_q ? -$signed({2'b00, pr}) : $signed({2'b00, pr});
		ps = mneg_q ? -$signed(p64) : $signed(p64);
		dotm = acds_pkg::rnd30(acds_pkg::mag64(acc_q));
		dotc = (dotm > 34'h0_4000_0000) ? 32'h4000_0000 : dotm[31:0];
		drc = dr_q;
		if (dr_q > DR_LIM)
			drc = DR_LIM;
		else if (dr_q < -DR_LIM)
			drc = -DR_LIM;
		num_c = 38'(da_q) - 38'(prs);
		num_m = num_c[37] ? (~num_c + 38'd1) : num_c;
		uq = (div_quo > acds_pkg::ONE30) ? 32'h4000_0000 : div_quo[31:0];
		v33 = {t_q[31], t_q} - {sp_q[31], sp_q};
		vmag = v33[32] ? (~v33 + 33'd1) : v33;
		hsum = {2'b00, vmag, 1'b0} + HALF;
		hval = hsum >> FRAC_BITS;
		sval = hval << (FRAC_BITS - 1);
		snap_c = acds_pkg::sat32(v33[32] ? -$signed(64'(sval)) : $signed(64'(sval)));
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tuser = ook_q;
	assign m_axis_tdata = {opos_q[2], opos_q[1], opos_q[0], osnap_q, ot_q};
	assign out_load = (state_q == ST_DONE) && (!ov_q || m_axis_tready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q[0] <= '0;
			st_q[1] <= '0;
			st_q[2] <= '0;
			ax_q[0] <= '0;
			ax_q[1] <= 32'sd65536;
			ax_q[2] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				acds_pkg::CFG_START_X: st_q[0] <= cfg_data;
				acds_pkg::CFG_START_Y: st_q[1] <= cfg_data;
				acds_pkg::CFG_START_Z: st_q[2] <= cfg_data;
				acds_pkg::CFG_AXIS_X: ax_q[0] <= cfg_data;
				acds_pkg::CFG_AXIS_Y: ax_q[1] <= cfg_data;
				acds_pkg::CFG_AXIS_Z: ax_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			sqrt_start_q <= 1'b0;
			ov_q <= 1'b0;
			sp_q <= '0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			sqrt_start_q <= 1'b0;
			if (out_load)
				ov_q <= 1'b1;
			else if (ov_q && m_axis_tready)
				ov_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						act_q <= s_axis_tuser[0];
						for (int i = 0; i < 3; i++) begin
							org_q[i] <= s_axis_tdata[32*i +: 32];
							dir_q[i] <= s_axis_tdata[96 + 32*i +: 32];
							mag_q[i] <= acds_pkg::mag32(ax_q[i]);
							neg_q[i] <= ax_q[i][31];
						end
						vsel_q <= 1'b0;
						k_q <= '0;
						ok_q <= 1'b0;
						t_q <= '0;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					// shift left until the largest component reaches 2^29
					if (mx != 32'd0 && mx < 32'h2000_0000) begin
						for (int i = 0; i < 3; i++)
							mag_q[i] <= mag_q[i] << 1;
						k_q <= k_q + 5'd1;
					end else begin
						cnt_q <= '0;
						sq_q <= '0;
						state_q <= ST_SQ_GO;
					end
				end
				ST_SQ_GO: begin
					mul_a_q <= MW'(mag_q[cnt_q[1:0]]);
					mul_b_q <= MW'(mag_q[cnt_q[1:0]]);
					mul_start_q <= 1'b1;
					state_q <= ST_SQ_WAIT;
				end
				ST_SQ_WAIT: begin
					if (mul_done) begin
						sq_q <= sq_q + p64;
						cnt_q <= cnt_q + 4'd1;
						if (cnt_q == 4'd2) begin
							l2_q <= sq_q + p64;
							state_q <= ST_UNSH;
						end else begin
							state_q <= ST_SQ_GO;
						end
					end
				end
				ST_UNSH: begin
					// undo the normalization to get the raw squared length
					if (k_q != 5'd0) begin
						l2_q <= l2_q >> 2;
						k_q <= k_q - 5'd1;
					end else begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (!vsel_q && (l2_q == 64'd0 || l2_q <= EPS2)) begin
						ua_q[0] <= '0;
						ua_q[1] <= 32'sh4000_0000;
						ua_q[2] <= '0;
						vsel_q <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							mag_q[i] <= acds_pkg::mag32(dir_q[i]);
							neg_q[i] <= dir_q[i][31];
						end
						k_q <= '0;
						state_q <= ST_NORM;
					end else if (vsel_q && (l2_q == 64'd0 || l2_q < EPS2)) begin
						ok_q <= 1'b0;
						t_q <= '0;
						state_q <= ST_SNAP;
					end else begin
						sqrt_start_q <= 1'b1;
						state_q <= ST_SQRT_GO;
					end
				end
				ST_SQRT_GO: begin
					state_q <= ST_SQRT_WAIT;
				end
				ST_SQRT_WAIT: begin
					if (sqrt_done) begin
						len_q <= (sqrt_root == 32'd0) ? 32'd1 : sqrt_root;
						cnt_q <= '0;
						state_q <= ST_UDIV_GO;
					end
				end
				ST_UDIV_GO: begin
					div_n_q <= (64'(mag_q[cnt_q[1:0]]) << 30) + 64'(len_q >> 1);
					div_d_q <= 64'(len_q);
					div_start_q <= 1'b1;
					state_q <= ST_UDIV_WAIT;
				end
				ST_UDIV_WAIT: begin
					if (div_done) begin
						if (vsel_q)
							ur_q[cnt_q[1:0]] <= neg_q[cnt_q[1:0]] ? -$signed(uq) : $signed(uq);
						else
							ua_q[cnt_q[1:0]] <= neg_q[cnt_q[1:0]] ? -$signed(uq) : $signed(uq);
						cnt_q <= cnt_q + 4'd1;
						if (cnt_q != 4'd2) begin
							state_q <= ST_UDIV_GO;
						end else if (!vsel_q) begin
							vsel_q <= 1'b1;
							for (int i = 0; i < 3; i++) begin
								mag_q[i] <= acds_pkg::mag32(dir_q[i]);
								neg_q[i] <= dir_q[i][31];
							end
							k_q <= '0;
							state_q <= ST_NORM;
						end else begin
							cnt_q <= '0;
							acc_q <= '0;
							da_q <= '0;
							dr_q <= '0;
							state_q <= ST_DOT_GO;
						end
					end
				end
				ST_DOT_GO: begin
					mul_a_q <= dot_a;
					mul_b_q <= dot_b;
					mneg_q <= dot_neg;
					mul_start_q <= 1'b1;
					state_q <= ST_DOT_WAIT;
				end
				ST_DOT_WAIT: begin
					if (mul_done) begin
						if (cnt_q < 4'd3)
							acc_q <= acc_q + ps;
						else if (cnt_q < 4'd6)
							da_q <= da_q + prs;
						else
							dr_q <= dr_q + prs;
						cnt_q <= cnt_q + 4'd1;
						state_q <= (cnt_q == 4'd8) ? ST_DOT_END : ST_DOT_GO;
					end
				end
				ST_DOT_END: begin
					dot_q <= acc_q[63] ? -$signed(dotc) : $signed(dotc);
					state_q <= ST_DD_GO;
				end
				ST_DD_GO: begin
					mul_a_q <= MW'(acds_pkg::mag32(dot_q));
					mul_b_q <= MW'(acds_pkg::mag32(dot_q));
					mneg_q <= 1'b0;
					mul_start_q <= 1'b1;
					state_q <= ST_DD_WAIT;
				end
				ST_DD_WAIT: begin
					if (mul_done) begin
						den_q <= 32'h4000_0000 - pr[31:0];
						dr_q <= drc;
						if (64'(32'h4000_0000 - pr[31:0]) < acds_pkg::PAR_EPS) begin
							// nearly parallel: plain projection
							t_q <= acds_pkg::sat32(64'(da_q));
							ok_q <= 1'b1;
							state_q <= ST_SNAP;
						end else begin
							state_q <= ST_NUM_GO;
						end
					end
				end
				ST_NUM_GO: begin
					mul_a_q <= MW'(acds_pkg::mag32(dot_q));
					mul_b_q <= dr_q[35] ? MW'(-dr_q) : MW'(dr_q);
					mneg_q <= dot_q[31] ^ dr_q[35];
					mul_start_q <= 1'b1;
					state_q <= ST_NUM_WAIT;
				end
				ST_NUM_WAIT: begin
					if (mul_done) begin
						n_q <= num_m[36:0];
						nneg_q <= num_c[37];
						state_q <= ST_QCHK;
					end
				end
				ST_QCHK: begin
					ok_q <= 1'b1;
					if (39'(n_q) >= {5'd0, den_q, 2'b00}) begin
						t_q <= nneg_q ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
						state_q <= ST_SNAP;
					end else begin
						div_n_q <= (64'(n_q) << 30) + 64'(den_q >> 1);
						div_d_q <= 64'(den_q);
						div_start_q <= 1'b1;
						state_q <= ST_Q_GO;
					end
				end
				ST_Q_GO: begin
					state_q <= ST_Q_WAIT;
				end
				ST_Q_WAIT: begin
					if (div_done) begin
						t_q <= acds_pkg::sat32(nneg_q ? -$signed(div_quo) : $signed(div_quo));
						state_q <= ST_SNAP;
					end
				end
				ST_SNAP: begin
					for (int i = 0; i < 3; i++)
						pos_q[i] <= st_q[i];
					snap_q <= '0;
					cnt_q <= '0;
					if (act_q == acds_pkg::ACT_BEGIN) begin
						sp_q <= ok_q ? t_q : 32'sd0;
						state_q <= ST_DONE;
					end else if (!ok_q) begin
						state_q <= ST_DONE;
					end else begin
						snap_q <= snap_c;
						state_q <= ST_POS_GO;
					end
				end
				ST_POS_GO: begin
					mul_a_q <= MW'(acds_pkg::mag32(ua_q[cnt_q[1:0]]));
					mul_b_q <= MW'(acds_pkg::mag32(snap_q));
					mneg_q <= ua_q[cnt_q[1:0]][31] ^ snap_q[31];
					mul_start_q <= 1'b1;
					state_q <= ST_POS_WAIT;
				end
				ST_POS_WAIT: begin
					if (mul_done) begin
						pos_q[cnt_q[1:0]] <= acds_pkg::sat32(64'(st_q[cnt_q[1:0]]) + 64'(prs));
						cnt_q <= cnt_q + 4'd1;
						state_q <= (cnt_q == 4'd2) ? ST_DONE : ST_POS_GO;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_load) begin
						ook_q <= ok_q;
						ot_q <= t_q;
						osnap_q <= snap_q;
						for (int i = 0; i < 3; i++)
							opos_q[i] <= pos_q[i];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/acds_chk.sv]
// Port-level checker for the constrained drag solver, bound to the top level.
// Depends on axis_constrained_drag_solve_unit_defines.svh.
`include "axis_constrained_drag_solve_unit_defines.svh"

module acds_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [159:0] m_axis_tdata,
	input logic [0:0]   m_axis_tuser
);

	// a stalled result holds
	`ACDS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// a failed item carries no parameter and no movement
	`ACDS_ASSERT_IMP(a_fail_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[63:0] == 64'd0, "failed item with nonzero parameter")

	// one item in work at a time
	`ACDS_ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")

endmodule

bind axis_constrained_drag_solve_unit acds_chk u_acds_chk (.*);

[tb/axis_constrained_drag_solve_unit_checker.sv]
// Checker for the constrained drag solver: watches config writes and both streams,
// predicts each result item and compares it field by field. Uses acds_pkg.
`timescale 1ns / 100ps

module axis_constrained_drag_solve_unit_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,
	input  logic [0:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [159:0] m_axis_tdata,
	input  logic [0:0]   m_axis_tuser,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	output int           fail_count,
	output int           pending
);
	localparam int FB = acds_pkg::FRAC_BITS_DEF;
	localparam longint unsigned LEN_EPS = ((64'd1 << FB) + 64'd5000) / 64'd10000;
	localparam longint ONE = 64'sd1 << 30;
	localparam longint PAR_E = (ONE + 5000) / 10000;

	typedef struct {
		logic   ok;
		longint t;
		longint snap;
		longint pos[3];
	} drag_result_t;

	logic signed [31:0] start_pos[3];
	logic signed [31:0] axis_dir[3];
	longint begin_param;
	drag_result_t result_q[$];

	assign pending = result_q.size();

	function automatic longint unsigned mag(longint x);
		return x < 0 ? 64'd0 - longint'(x) : x;
	endfunction

	function automatic longint sat(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint rsh_rnd(longint x, int sh);
		longint unsigned m;
		m = (mag(x) + (64'd1 << (sh - 1))) >> sh;
		return x < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned isqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned len_sq(longint d[3]);
		longint unsigned s;
		s = 0;
		for (int i = 0; i < 3; i++) s += mag(d[i]) * mag(d[i]);
		return s;
	endfunction

	// scale up to keep precision, then divide each component by the length
	function automatic void unit_vec(input longint d[3], output longint u[3]);
		longint unsigned m[3], mx, sq, len, q;
		mx = 0;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag(d[i]);
			if (m[i] > mx) mx = m[i];
		end
		while (mx != 0 && mx < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++) m[i] <<= 1;
			mx <<= 1;
		end
		for (int i = 0; i < 3; i++) sq += m[i] * m[i];
		len = isqrt(sq);
		if (len == 0) len = 1;
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << 30) + len / 2) / len;
			if (q > ONE) q = ONE;
			u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
		end
	endfunction

	function automatic drag_result_t predict_drag(logic action, logic [191:0] data);
		drag_result_t res;
		longint org[3], dir[3], st[3], ax[3], a[3], r[3], diff[3];
		longint dot, dd, den, d_a, d_r, num, q, v, s, t;
		longint unsigned l2, n, hi, rem, h;
		logic ok;
		for (int i = 0; i < 3; i++) begin
			org[i] = longint'($signed(data[32*i +: 32]));
			dir[i] = longint'($signed(data[96 + 32*i +: 32]));
			st[i] = longint'(start_pos[i]);
			ax[i] = longint'(axis_dir[i]);
		end
		l2 = len_sq(ax);
		if (l2 == 0 || l2 <= LEN_EPS * LEN_EPS) begin
			a[0] = 0;
			a[1] = ONE;
			a[2] = 0;
		end else
			unit_vec(ax, a);
		t = 0;
		l2 = len_sq(dir);
		ok = !(l2 == 0 || l2 < LEN_EPS * LEN_EPS);
		if (ok) begin
			unit_vec(dir, r);
			dot = 0;
			d_a = 0;
			d_r = 0;
			for (int i = 0; i < 3; i++) begin
				diff[i] = org[i] - st[i];
				dot += r[i] * a[i];
				d_a += rsh_rnd(diff[i] * a[i], 30);
				d_r += rsh_rnd(diff[i] * r[i], 30);
			end
			dot = rsh_rnd(dot, 30);
			if (dot > ONE) dot = ONE;
			if (dot < -ONE) dot = -ONE;
			dd = rsh_rnd(dot * dot, 30);
			den = ONE - dd;
			if (den < PAR_E)
				t = sat(d_a);
			else begin
				if (d_r > (64'sd1 <<< 33) - 1) d_r = (64'sd1 <<< 33) - 1;
				if (d_r < -((64'sd1 <<< 33) - 1)) d_r = -((64'sd1 <<< 33) - 1);
				num = d_a - rsh_rnd(dot * d_r, 30);
				n = mag(num);
				hi = n / den;
				rem = n % den;
				if (hi >= 4)
					q = 64'sd1 <<< 32;
				else
					q = (hi << 30) + ((rem << 30) + den / 2) / den;
				t = sat(num < 0 ? -q : q);
			end
		end
		res.ok = ok;
		res.snap = 0;
		for (int i = 0; i < 3; i++) res.pos[i] = st[i];
		if (action == acds_pkg::ACT_BEGIN) begin
			begin_param = ok ? t : 0;
			if (!ok) t = 0;
		end else if (!ok)
			t = 0;
		else begin
			v = t - begin_param;
			h = (2 * mag(v) + (64'd1 << (FB - 1))) >> FB;
			s = h * (64'sd1 <<< (FB - 1));
			res.snap = sat(v < 0 ? -s : s);
			for (int i = 0; i < 3; i++)
				res.pos[i] = sat(st[i] + rsh_rnd(a[i] * res.snap, 30));
		end
		res.t = t;
		return res;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		drag_result_t want;
		if (!arst_n) begin
			start_pos[0] = '0;
			start_pos[1] = '0;
			start_pos[2] = '0;
			axis_dir[0] = '0;
			axis_dir[1] = 32'sd65536;
			axis_dir[2] = '0;
			begin_param = 0;
			result_q.delete();
		end else begin
			// compare before predicting so a same-edge input never alters this check
			if (m_axis_tvalid && m_axis_tready) begin
				if (result_q.size() == 0)
					report("unexpected item", 0, 0);
				else begin
					want = result_q.pop_front();
					if (m_axis_tuser[0] !== want.ok)
						report("ok", m_axis_tuser[0], want.ok);
					if ($signed(m_axis_tdata[31:0]) !== 32'(want.t))
						report("axis_param", $signed(m_axis_tdata[31:0]), want.t);
					if ($signed(m_axis_tdata[63:32]) !== 32'(want.snap))
						report("snapped_move", $signed(m_axis_tdata[63:32]), want.snap);
					for (int i = 0; i < 3; i++)
						if ($signed(m_axis_tdata[64 + 32*i +: 32]) !== 32'(want.pos[i]))
							report($sformatf("new_pos[%0d]", i),
								$signed(m_axis_tdata[64 + 32*i +: 32]), want.pos[i]);
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				result_q.push_back(predict_drag(s_axis_tuser[0], s_axis_tdata));
			if (cfg_we) begin
				case (acds_pkg::cfg_idx_t'(cfg_index))
					acds_pkg::CFG_START_X: start_pos[0] = cfg_data;
					acds_pkg::CFG_START_Y: start_pos[1] = cfg_data;
					acds_pkg::CFG_START_Z: start_pos[2] = cfg_data;
					acds_pkg::CFG_AXIS_X:  axis_dir[0] = cfg_data;
					acds_pkg::CFG_AXIS_Y:  axis_dir[1] = cfg_data;
					acds_pkg::CFG_AXIS_Z:  axis_dir[2] = cfg_data;
					default: ;
				endcase
			end
		end
	end

endmodule

[tb/axis_constrained_drag_solve_unit_tb.sv]
// Testbench top for the constrained drag solver: clock, reset, config phases,
// ray stimulus and the verdict. Depends on acds_pkg and the checker module.
`timescale 1ns / 100ps

module axis_constrained_drag_solve_unit_tb;
	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// ray_org_x, ray_org_y, ray_org_z, ray_dir_x, ray_dir_y, ray_dir_z
	logic [191:0] s_axis_tdata;
	// action
	logic [0:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// axis_param, snapped_move, new_pos_x, new_pos_y, new_pos_z
	logic [159:0] m_axis_tdata;
	// ok
	logic [0:0]   m_axis_tuser;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;
	int           fail_count;
	int           pending;
	int           stall_left;
	logic         no_gaps;
	logic signed [31:0] cur_axis[3];

	axis_constrained_drag_solve_unit u_dut (.*);

	axis_constrained_drag_solve_unit_checker u_check (.*);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: mostly ready, short stalls, now and then a long one
	initial stall_left = 0;
	always @(posedge clk) begin
		int r;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			r = $urandom_range(0, 99);
			if (r < 12)
				stall_left <= $urandom_range(1, 4);
			else if (r < 14)
				stall_left <= $urandom_range(30, 1500);
		end
	end

	task automatic write_reg(acds_pkg::cfg_idx_t idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_config(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
		logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
		// drop valid and let the last accepted item reach the checker first
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		write_reg(acds_pkg::CFG_START_X, sx);
		write_reg(acds_pkg::CFG_START_Y, sy);
		write_reg(acds_pkg::CFG_START_Z, sz);
		write_reg(acds_pkg::CFG_AXIS_X, ax);
		write_reg(acds_pkg::CFG_AXIS_Y, ay);
		write_reg(acds_pkg::CFG_AXIS_Z, az);
		cfg_we <= 1'b0;
		cur_axis[0] = ax;
		cur_axis[1] = ay;
		cur_axis[2] = az;
	endtask

	// hold the item until accepted, then idle for a random gap, which may be zero
	task automatic send_ray(logic action, logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
		logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
		int r, gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= action;
		s_axis_tdata <= {dz, dy, dx, oz, oy, ox};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		r = $urandom_range(0, 99);
		gap = (no_gaps || r < 60) ? 0 : (r < 94) ? $urandom_range(1, 5)
			: $urandom_range(40, 2000);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			2, 3: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
		endcase
	endfunction

	function automatic logic [31:0] pick_dir(int i, int mode);
		case (mode)
			0: return 32'($signed($urandom_range(0, 8)) - 4);   // short ray
			1: return cur_axis[i];                              // parallel to axis
			2: return -cur_axis[i];
			3: return $urandom();
			default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	task automatic random_drags(int count);
		int sent, moves, mode;
		logic [31:0] o[3], d[3];
		sent = 0;
		no_gaps = ($urandom_range(0, 3) == 0);
		while (sent < count) begin
			moves = $urandom_range(0, 8);
			for (int k = 0; k <= moves; k++) begin
				mode = $urandom_range(0, 19);
				mode = (mode < 1) ? 0 : (mode < 3) ? 1 : (mode < 4) ? 2 : (mode < 7) ? 3 : 4;
				for (int i = 0; i < 3; i++) begin
					o[i] = pick_coord();
					d[i] = pick_dir(i, mode);
				end
				// a stray begin inside a move run breaks the sequence now and then
				send_ray((k == 0 || $urandom_range(0, 19) == 0) ? acds_pkg::ACT_BEGIN
					: acds_pkg::ACT_MOVE, o[0], o[1], o[2], d[0], d[1], d[2]);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		no_gaps = 1'b0;
		cur_axis[0] = 0;
		cur_axis[1] = 32'sd65536;
		cur_axis[2] = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: axis +y through the origin
		send_ray(acds_pkg::ACT_BEGIN, 0, 0, 0, 32'h0001_0000, 0, 0);
		send_ray(acds_pkg::ACT_MOVE, 0, 32'h0003_4000, 0, 32'h0001_0000, 0, 0);
		send_ray(acds_pkg::ACT_MOVE, 0, 32'hFFFE_C000, 0, 0, 0, 32'h0001_0000);
		send_ray(acds_pkg::ACT_MOVE, 0, 32'h0000_4000, 0, 32'h0001_0000, 0, 0);
		send_ray(acds_pkg::ACT_MOVE, 0, 32'hFFFF_C000, 0, 32'h0001_0000, 0, 0);
		send_ray(acds_pkg::ACT_MOVE, 0, 0, 0, 0, 0, 0);
		send_ray(acds_pkg::ACT_MOVE, 0, 0, 0, 4, 4, 4);
		send_ray(acds_pkg::ACT_BEGIN, 0, 0, 0, 2, 2, 1);
		send_ray(acds_pkg::ACT_MOVE, 32'h0001_0000, 32'h0005_0000, 0, 0, 32'h0001_0000, 0);
		send_ray(acds_pkg::ACT_MOVE, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0);
		send_ray(acds_pkg::ACT_BEGIN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_ray(acds_pkg::ACT_MOVE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
		send_ray(acds_pkg::ACT_MOVE, 0, 32'h7FFF_FFFF, 0, 32'h0001_0000, 32'h0000_0100, 0);
		// short axis falls back to +y
		set_config(0, 0, 0, 0, 0, 0);
		send_ray(acds_pkg::ACT_BEGIN, 0, 0, 0, 32'h0001_0000, 0, 0);
		send_ray(acds_pkg::ACT_MOVE, 0, 32'h0002_8000, 0, 32'h0001_0000, 0, 0);
		set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 3, 3, 3);
		send_ray(acds_pkg::ACT_BEGIN, 0, 0, 0, 32'h0001_0000, 0, 0);
		send_ray(acds_pkg::ACT_MOVE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 32'h0001_0000);

		set_config(0, 0, 0, 0, 32'h0001_0000, 0);
		random_drags(130);
		set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		random_drags(130);
		set_config($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
		random_drags(130);
		set_config(32'h0001_8000, 32'hFFFD_0000, 32'h0000_4000,
			32'h0001_0000, 32'h0001_0000, 0);
		random_drags(130);
		set_config(0, 0, 0, 0, 0, 32'h8000_0000);
		random_drags(130);
		set_config(32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)), 0,
			32'($signed($urandom_range(0, 1 << 22)) - (1 << 21)),
			$urandom(), 5, $urandom());
		random_drags(130);

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
